@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sparse-grid upsampler.
// Clocked concurrent checks with a synchronous reset as the disable condition.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SGBU_ASSERT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgbu assertion failed");

// Next-cycle implication.
`define SGBU_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgbu assertion failed");

`endif

@@ rtl/sgbu_pkg.sv @@
// Shared types and constants of the sparse-grid bilinear upsampler.
// No dependencies; used by the channel interfaces and the top level.
package sgbu_pkg;

  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int SAMPLE_W  = 17;
  localparam int VALUE_W   = 25;
  localparam int FRAC_BITS = 8;
  localparam int QUO_W     = 25;
  localparam int SIZE_W    = 9;
  localparam int OFFSET_W  = 8;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_STEP = 16;

  localparam logic [SIZE_W-1:0]   RST_IMAGE_ROWS = 9'd256;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_COLS = 9'd256;
  localparam logic [OFFSET_W-1:0] RST_OFFSET     = 8'd0;
  localparam logic [STEP_W-1:0]   RST_STEP       = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS = 3'd0,
    REG_IMAGE_COLS = 3'd1,
    REG_OFFSET_COL = 3'd2,
    REG_OFFSET_ROW = 3'd3,
    REG_STEP_COL   = 3'd4,
    REG_STEP_ROW   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

@@ rtl/sgbu_if.sv @@
// Valid/ready channel interfaces for input items and results.
// Depends on sgbu_pkg for the field widths.
interface sgbu_item_if import sgbu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ROW_W-1:0]           pixel_row;
  logic [COL_W-1:0]           pixel_col;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, operation, pixel_row, pixel_col, sample_value, input ready);
  modport sink   (input valid, operation, pixel_row, pixel_col, sample_value, output ready);
endinterface

interface sgbu_result_if import sgbu_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] interp_value;
  logic                      outside_region;
  logic [ROW_W-1:0]          result_row;
  logic [COL_W-1:0]          result_col;

  modport source (output valid, interp_value, outside_region, result_row, result_col,
                  input ready);
  modport sink   (input valid, interp_value, outside_region, result_row, result_col,
                  output ready);
endinterface

@@ rtl/sparse_grid_bilinear_upsampler.sv @@
// Sparse-grid bilinear upsampler: 14-stage pipeline, one item per cycle sustained while results.ready is high.
// A query result passes through every stage register after its input transfer and waits
// in stage 14 while the output is stalled.
// Throughput: 1 item per cycle unless the output stalls; the four neighbor reads come from four replicated stores.
// Reset (rst, synchronous) clears stage valids and restores the config registers;
// the sample stores are not cleared and hold undefined data until written.
`include "assert_macros.svh"

module sparse_grid_bilinear_upsampler import sgbu_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_STEP = DEF_MAX_STEP
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sgbu_item_if.sink             items,
  sgbu_result_if.source         results
);

  // Widths derived from the parameters.
  localparam int SW   = $clog2(MAX_STEP + 1);   // step and remainder
  localparam int WW   = 2 * SW;                 // weights and divisor
  localparam int RAW  = $clog2(MAX_ROWS);
  localparam int CAW  = $clog2(MAX_COLS);
  localparam int AW   = RAW + CAW;
  localparam int DEPTH = 1 << AW;
  localparam int CW0  = $clog2(256 + MAX_STEP);
  localparam int CW1  = $clog2(MAX_ROWS + 1);
  localparam int CW2  = $clog2(MAX_COLS + 1);
  localparam int CWA  = (CW0 > CW1) ? CW0 : CW1;
  localparam int CWB  = (CWA > CW2) ? CWA : CW2;
  localparam int CW   = (CWB > SIZE_W) ? CWB : SIZE_W;  // coordinates and limits
  localparam int PW   = SAMPLE_W + WW + 1;      // one sample times weight
  localparam int NUMW = PW + 2;                 // sum of four products
  localparam int NSW  = NUMW + FRAC_BITS + 1;   // scaled numerator with headroom
  localparam int HALF = ROW_W / 2;
  localparam int DIV_BITS = 5;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;
  localparam int NBR  = 4;
  localparam int S_DIV0 = 9;
  localparam int NS   = S_DIV0 + DIV_STAGES;    // output stage index

  typedef struct packed {
    logic             query;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             outside;
  } meta_t;

  // Remainder of a nibble of dividend bits, restoring form.
  function automatic logic [SW-1:0] mod_steps(input logic [SW-1:0] rem_in,
                                              input logic [HALF-1:0] bits,
                                              input logic [SW-1:0] d);
    logic [SW:0]   t;
    logic [SW-1:0] r;
    r = rem_in;
    for (int i = HALF - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[SW-1:0];
    end
    return r;
  endfunction

  // DIV_BITS quotient bits of the long division; low shifts out dividend, in quotient.
  function automatic logic [WW+QUO_W-1:0] div_steps(input logic [WW-1:0] rem_in,
                                                    input logic [QUO_W-1:0] low_in,
                                                    input logic [WW-1:0] d);
    logic [WW:0]      t;
    logic [WW-1:0]    r;
    logic [QUO_W-1:0] l;
    r = rem_in;
    l = low_in;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, l[QUO_W-1]};
      l = {l[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        l[0] = 1'b1;
      end
      r = t[WW-1:0];
    end
    return {r, l};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]   img_rows, img_cols;
  logic [OFFSET_W-1:0] off_col, off_row;
  logic [STEP_W-1:0]   step_col, step_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_rows <= RST_IMAGE_ROWS;
      img_cols <= RST_IMAGE_COLS;
      off_col  <= RST_OFFSET;
      off_row  <= RST_OFFSET;
      step_col <= RST_STEP;
      step_row <= RST_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_ROWS: img_rows <= cfg_data;
        REG_IMAGE_COLS: img_cols <= cfg_data;
        REG_OFFSET_COL: off_col  <= cfg_data[OFFSET_W-1:0];
        REG_OFFSET_ROW: off_row  <= cfg_data[OFFSET_W-1:0];
        REG_STEP_COL:   step_col <= cfg_data[STEP_W-1:0];
        REG_STEP_ROW:   step_row <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes to the store and steps to 1..MAX_STEP.
  logic [CW-1:0] rows_lim, cols_lim;
  logic [SW-1:0] dr, dc;

  always_comb begin
    rows_lim = (CW'(img_rows) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(img_rows);
    cols_lim = (CW'(img_cols) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(img_cols);
    if (step_row == '0)                      dr = SW'(1);
    else if (32'(step_row) > 32'(MAX_STEP)) dr = SW'(MAX_STEP);
    else                                    dr = SW'(step_row);
    if (step_col == '0)                      dc = SW'(1);
    else if (32'(step_col) > 32'(MAX_STEP)) dc = SW'(MAX_STEP);
    else                                    dc = SW'(step_col);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------------
  logic [NS:1]   v;
  logic [NS:1]   vin;
  logic [NS+1:1] rdy;
  meta_t         s5_meta;

  assign rdy[NS+1] = results.ready;
  for (genvar k = 1; k <= NS; k++) begin : g_ctl
    assign rdy[k] = !v[k] || rdy[k+1];
    if (k == 1) begin : g_first
      assign vin[k] = items.valid;
    end else if (k == 6) begin : g_drop
      // Drop writes once they have committed to the store.
      assign vin[k] = v[k-1] && s5_meta.query;
    end else begin : g_mid
      assign vin[k] = v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) v[k] <= vin[k];
      end
    end
  end

  assign items.ready = rdy[1];

  // ---------------------------------------------------------------------------
  // Stage 1: bounds checks and position relative to the grid origin.
  // ---------------------------------------------------------------------------
  logic                       in_row_ok, in_col_ok, in_outside;
  meta_t                      s1_meta;
  logic                       s1_wr;
  logic signed [SAMPLE_W-1:0] s1_val;
  logic [ROW_W-1:0]           s1_relr;
  logic [COL_W-1:0]           s1_relc;

  always_comb begin
    in_row_ok  = CW'(items.pixel_row) < rows_lim;
    in_col_ok  = CW'(items.pixel_col) < cols_lim;
    in_outside = !(in_row_ok && in_col_ok) || (items.pixel_row < off_row)
                 || (items.pixel_col < off_col);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_meta.query   <= (items.operation == OP_QUERY);
      s1_meta.row     <= items.pixel_row;
      s1_meta.col     <= items.pixel_col;
      s1_meta.outside <= in_outside;
      s1_wr   <= (items.operation == OP_WRITE) && in_row_ok && in_col_ok;
      s1_val  <= items.sample_value;
      s1_relr <= items.pixel_row - off_row;
      s1_relc <= items.pixel_col - off_col;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2-3: offset within the grid cell, high nibble then low nibble.
  // ---------------------------------------------------------------------------
  meta_t                      s2_meta, s3_meta;
  logic                       s2_wr, s3_wr;
  logic signed [SAMPLE_W-1:0] s2_val, s3_val;
  logic [SW-1:0]              s2_remr, s2_remc, s3_fr, s3_fc;
  logic [HALF-1:0]            s2_lowr, s2_lowc;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_meta <= s1_meta;
      s2_wr   <= s1_wr;
      s2_val  <= s1_val;
      s2_remr <= mod_steps('0, s1_relr[ROW_W-1:HALF], dr);
      s2_remc <= mod_steps('0, s1_relc[COL_W-1:HALF], dc);
      s2_lowr <= s1_relr[HALF-1:0];
      s2_lowc <= s1_relc[HALF-1:0];
    end
    if (rdy[3]) begin
      s3_meta <= s2_meta;
      s3_wr   <= s2_wr;
      s3_val  <= s2_val;
      s3_fr   <= mod_steps(s2_remr, s2_lowr, dr);
      s3_fc   <= mod_steps(s2_remc, s2_lowc, dc);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: neighbor coordinates, addresses, in-image masks and weights.
  // Neighbor order: 0 = (r0,c0), 1 = (r0+dr,c0), 2 = (r0,c0+dc), 3 = (r0+dr,c0+dc).
  // ---------------------------------------------------------------------------
  logic [CW-1:0] r0, c0, r1, c1, wrow, wcol;
  logic [SW-1:0] wc0, wr0;
  logic [CW-1:0] nb_r [NBR];
  logic [CW-1:0] nb_c [NBR];

  meta_t                      s4_meta;
  logic                       s4_wr;
  logic signed [SAMPLE_W-1:0] s4_val;
  logic [AW-1:0]              s4_waddr;
  logic [AW-1:0]              s4_addr [NBR];
  logic [NBR-1:0]             s4_ok;
  logic [WW-1:0]              s4_w [NBR];
  logic [WW-1:0]              s4_d;

  always_comb begin
    r0   = CW'(s3_meta.row) - CW'(s3_fr);
    c0   = CW'(s3_meta.col) - CW'(s3_fc);
    r1   = r0 + CW'(dr);
    c1   = c0 + CW'(dc);
    wrow = CW'(s3_meta.row);
    wcol = CW'(s3_meta.col);
    wc0  = dc - s3_fc;
    wr0  = dr - s3_fr;
    nb_r[0] = r0; nb_c[0] = c0;
    nb_r[1] = r1; nb_c[1] = c0;
    nb_r[2] = r0; nb_c[2] = c1;
    nb_r[3] = r1; nb_c[3] = c1;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_meta  <= s3_meta;
      s4_wr    <= s3_wr;
      s4_val   <= s3_val;
      s4_waddr <= {wrow[RAW-1:0], wcol[CAW-1:0]};
      for (int g = 0; g < NBR; g++) begin
        s4_addr[g] <= {nb_r[g][RAW-1:0], nb_c[g][CAW-1:0]};
        s4_ok[g]   <= (nb_r[g] < rows_lim) && (nb_c[g] < cols_lim);
      end
      s4_w[0] <= WW'(wc0) * WW'(wr0);
      s4_w[1] <= WW'(wc0) * WW'(s3_fr);
      s4_w[2] <= WW'(s3_fc) * WW'(wr0);
      s4_w[3] <= WW'(s3_fc) * WW'(s3_fr);
      s4_d    <= WW'(dc) * WW'(dr);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: four replicated sample stores, written together, read one each.
  // A write commits as it leaves stage 4, so a query behind it sees the data.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] s5_rdat [NBR];
  logic [NBR-1:0]             s5_ok;
  logic [WW-1:0]              s5_w [NBR];
  logic [WW-1:0]              s5_d;
  logic                       store_we;

  assign store_we = rdy[5] && v[4] && s4_wr;

  for (genvar g = 0; g < NBR; g++) begin : g_store
    logic signed [SAMPLE_W-1:0] store [DEPTH];
    always_ff @(posedge clk) begin
      if (store_we) store[s4_waddr] <= s4_val;
      if (rdy[5])   s5_rdat[g] <= store[s4_addr[g]];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_meta <= s4_meta;
      s5_ok   <= s4_ok;
      s5_w    <= s4_w;
      s5_d    <= s4_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: sample times weight; neighbors beyond the image read as zero.
  // Neighbors with zero weight may never have been written, so force them to zero too.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] samp [NBR];
  logic signed [WW:0]         wsg  [NBR];
  meta_t                      s6_meta;
  logic signed [PW-1:0]       s6_p [NBR];
  logic [WW-1:0]              s6_d;

  always_comb begin
    for (int g = 0; g < NBR; g++) begin
      samp[g] = (s5_ok[g] && (s5_w[g] != '0)) ? s5_rdat[g] : '0;
      wsg[g]  = $signed({1'b0, s5_w[g]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_meta <= s5_meta;
      s6_d    <= s5_d;
      for (int g = 0; g < NBR; g++) begin
        s6_p[g] <= PW'(samp[g]) * PW'(wsg[g]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: sum of the four products.
  // ---------------------------------------------------------------------------
  meta_t                  s7_meta;
  logic signed [NUMW-1:0] s7_num;
  logic [WW-1:0]          s7_d;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_meta <= s6_meta;
      s7_d    <= s6_d;
      s7_num  <= NUMW'(s6_p[0]) + NUMW'(s6_p[1]) + NUMW'(s6_p[2]) + NUMW'(s6_p[3]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: scale to Q.8 and fold the sign so that an unsigned divide floors:
  // a negative numerator n divides as (-n + d - 1), and the quotient is negated.
  // ---------------------------------------------------------------------------
  logic signed [NSW-1:0] nsh, dsg, mfull;
  logic [QUO_W+WW-1:0]   m;

  always_comb begin
    nsh   = {s7_num[NUMW-1], s7_num, FRAC_BITS'(0)};
    dsg   = $signed({{(NSW-WW){1'b0}}, s7_d});
    mfull = s7_num[NUMW-1] ? (dsg - nsh - NSW'(1)) : nsh;
    m     = mfull[QUO_W+WW-1:0];
  end

  meta_t            dv_meta [DIV_STAGES+1];
  logic             dv_neg  [DIV_STAGES+1];
  logic [WW-1:0]    dv_d    [DIV_STAGES+1];
  logic [WW-1:0]    dv_rem  [DIV_STAGES+1];
  logic [QUO_W-1:0] dv_low  [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      dv_meta[0] <= s7_meta;
      dv_neg[0]  <= s7_num[NUMW-1];
      dv_d[0]    <= s7_d;
      dv_rem[0]  <= m[QUO_W+WW-1:QUO_W];
      dv_low[0]  <= m[QUO_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 9-13: restoring divide by the saturated steps dc*dr, DIV_BITS bits per stage.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rdy[S_DIV0+k]) begin
        dv_meta[k+1] <= dv_meta[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_d[k+1]    <= dv_d[k];
        {dv_rem[k+1], dv_low[k+1]} <= div_steps(dv_rem[k], dv_low[k], dv_d[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 14: restore the sign, zero outside positions, hold for the output transfer.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] out_val;
  meta_t                     out_meta;

  always_ff @(posedge clk) begin
    if (rdy[NS]) begin
      out_meta <= dv_meta[DIV_STAGES];
      if (dv_meta[DIV_STAGES].outside) begin
        out_val <= '0;
      end else if (dv_neg[DIV_STAGES]) begin
        out_val <= VALUE_W'(-dv_low[DIV_STAGES]);
      end else begin
        out_val <= VALUE_W'(dv_low[DIV_STAGES]);
      end
    end
  end

  assign results.valid          = v[NS];
  assign results.interp_value   = out_val;
  assign results.outside_region = out_meta.outside;
  assign results.result_row     = out_meta.row;
  assign results.result_col     = out_meta.col;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SGBU_ASSERT(a_no_write_past_store, clk, rst, v[6], s6_meta.query)
  `SGBU_ASSERT_NEXT(a_read_data_held, clk, rst, v[5] && !rdy[6], $stable(s5_meta))
  `SGBU_ASSERT(a_outside_zero, clk, rst, results.valid && results.outside_region,
               results.interp_value == '0)
  `SGBU_ASSERT(a_empty_entry_ready, clk, rst, !v[1], items.ready)

endmodule
